// ----- src/dts_pkg.sv -----
// ----------------------------------------------------------------------------
// dts_pkg
// Types, character codes and scanner helper functions shared by the scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package dts_pkg;

  localparam int START_W = 16;
  localparam int LEN_W   = 8;
  localparam int LINE_W  = 16;

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // letters used by the keyword states
  localparam logic [7:0] CH_LC_B = 8'h62;
  localparam logic [7:0] CH_LC_D = 8'h64;
  localparam logic [7:0] CH_LC_E = 8'h65;
  localparam logic [7:0] CH_LC_I = 8'h69;
  localparam logic [7:0] CH_LC_L = 8'h6C;
  localparam logic [7:0] CH_LC_N = 8'h6E;
  localparam logic [7:0] CH_LC_O = 8'h6F;
  localparam logic [7:0] CH_LC_T = 8'h74;
  localparam logic [7:0] CH_LC_U = 8'h75;

  typedef enum logic [4:0] {
    ST_START   = 5'd0,
    ST_INT     = 5'd1,
    ST_DOT     = 5'd2,
    ST_FRAC    = 5'd3,
    ST_SLASH   = 5'd4,
    ST_COMMENT = 5'd5,
    ST_IDENT   = 5'd6,
    ST_KW_I    = 5'd7,
    ST_KW_IN   = 5'd8,
    ST_KW_INT  = 5'd9,
    ST_KW_D    = 5'd10,
    ST_KW_DO   = 5'd11,
    ST_KW_DOU  = 5'd12,
    ST_KW_DOUB = 5'd13,
    ST_KW_DOUBL = 5'd14,
    ST_KW_DOUBLE = 5'd15
  } scan_state_t;

  typedef enum logic [2:0] {
    KIND_SEP     = 3'd0,
    KIND_OP      = 3'd1,
    KIND_REAL    = 3'd2,
    KIND_INT     = 3'd3,
    KIND_COMMENT = 3'd4,
    KIND_KEYWORD = 3'd5,
    KIND_IDENT   = 3'd6,
    KIND_ERROR   = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [START_W-1:0]  start;
    logic [LEN_W-1:0]    length;
    logic [LINE_W-1:0]   line;
    logic                last;
  } token_t;

  typedef struct packed {
    logic   valid0;
    logic   valid1;
    token_t tok0;
    token_t tok1;
  } step_out_t;

  typedef struct packed {
    logic        emit;
    kind_t       kind;
    logic        halt;
    logic        go;
    scan_state_t nstate;
  } start_out_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic [7:0] kw_expect(input scan_state_t st);
    logic [7:0] e;
    unique case (st)
      ST_KW_I:      e = CH_LC_N;
      ST_KW_IN:     e = CH_LC_T;
      ST_KW_INT:    e = CH_SPACE;
      ST_KW_D:      e = CH_LC_O;
      ST_KW_DO:     e = CH_LC_U;
      ST_KW_DOU:    e = CH_LC_B;
      ST_KW_DOUB:   e = CH_LC_L;
      ST_KW_DOUBL:  e = CH_LC_E;
      ST_KW_DOUBLE: e = CH_SPACE;
      default:      e = CH_SPACE;
    endcase
    return e;
  endfunction

  // ST_START here means the keyword is complete
  function automatic scan_state_t kw_follow(input scan_state_t st);
    scan_state_t f;
    unique case (st)
      ST_KW_I:     f = ST_KW_IN;
      ST_KW_IN:    f = ST_KW_INT;
      ST_KW_D:     f = ST_KW_DO;
      ST_KW_DO:    f = ST_KW_DOU;
      ST_KW_DOU:   f = ST_KW_DOUB;
      ST_KW_DOUB:  f = ST_KW_DOUBL;
      ST_KW_DOUBL: f = ST_KW_DOUBLE;
      default:     f = ST_START;
    endcase
    return f;
  endfunction

  // decision for a byte seen in the start state
  function automatic start_out_t start_char(input logic [7:0] c);
    start_out_t s;
    s.emit   = 1'b0;
    s.kind   = KIND_ERROR;
    s.halt   = 1'b0;
    s.go     = 1'b0;
    s.nstate = ST_START;
    if (c == CH_SPACE || c == CH_NL || c == CH_TAB) begin
      s.emit = 1'b0;
    end else if (c == CH_SEMI || c == CH_EQ) begin
      s.emit = 1'b1;
      s.kind = KIND_SEP;
    end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR) begin
      s.emit = 1'b1;
      s.kind = KIND_OP;
    end else if (is_digit(c)) begin
      s.go     = 1'b1;
      s.nstate = ST_INT;
    end else if (c == CH_SLASH) begin
      s.go     = 1'b1;
      s.nstate = ST_SLASH;
    end else if (c == CH_LC_I) begin
      s.go     = 1'b1;
      s.nstate = ST_KW_I;
    end else if (c == CH_LC_D) begin
      s.go     = 1'b1;
      s.nstate = ST_KW_D;
    end else if (is_alpha(c)) begin
      s.go     = 1'b1;
      s.nstate = ST_IDENT;
    end else begin
      s.emit = 1'b1;
      s.kind = KIND_ERROR;
      s.halt = 1'b1;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- src/dts_scan_core.sv -----
// ----------------------------------------------------------------------------
// dts_scan_core
// Scanner state registers and the combinational step that yields up to two tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module dts_scan_core #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [7:0]        text_byte,
  input  wire logic              end_of_text,
  output dts_pkg::step_out_t     res
);

  dts_pkg::scan_state_t scan_state, scan_state_next;
  logic [dts_pkg::LEN_W-1:0]  lexeme_length, lexeme_length_next;
  logic [POSITION_BITS-1:0]   lexeme_start, lexeme_start_next;
  logic [POSITION_BITS-1:0]   text_position, text_position_next;
  logic [dts_pkg::LINE_W-1:0] line_count, line_count_next;
  logic                       halted, halted_next;

  dts_pkg::start_out_t        sc;
  logic [dts_pkg::LEN_W-1:0]  ext_len;
  logic [dts_pkg::LINE_W-1:0] la;
  logic                       fin;
  dts_pkg::kind_t             fin_kind;
  logic [dts_pkg::LEN_W-1:0]  fin_len;
  logic [dts_pkg::LINE_W-1:0] fin_line;
  logic                       rescan;
  dts_pkg::token_t            pend_tok, sc_tok;

  always_comb begin
    sc       = dts_pkg::start_char(text_byte);
    ext_len  = (lexeme_length == '1) ? lexeme_length : lexeme_length + 1'b1;
    la       = (text_byte == dts_pkg::CH_NL && line_count != '1) ?
               line_count + 1'b1 : line_count;

    scan_state_next    = scan_state;
    lexeme_length_next = lexeme_length;
    lexeme_start_next  = lexeme_start;
    text_position_next = text_position;
    line_count_next    = line_count;
    halted_next        = halted;
    fin      = 1'b0;
    fin_kind = dts_pkg::KIND_ERROR;
    fin_len  = lexeme_length;
    fin_line = line_count;
    rescan   = 1'b0;

    if (end_of_text) begin
      if (!halted) begin
        fin = 1'b1;
        unique case (scan_state) inside
          dts_pkg::ST_INT:     fin_kind = dts_pkg::KIND_INT;
          dts_pkg::ST_DOT:     fin_kind = dts_pkg::KIND_ERROR;
          dts_pkg::ST_FRAC:    fin_kind = dts_pkg::KIND_REAL;
          dts_pkg::ST_SLASH:   fin_kind = dts_pkg::KIND_OP;
          dts_pkg::ST_COMMENT: fin_kind = dts_pkg::KIND_COMMENT;
          dts_pkg::ST_IDENT, dts_pkg::ST_KW_I, dts_pkg::ST_KW_IN, dts_pkg::ST_KW_INT,
          dts_pkg::ST_KW_D, dts_pkg::ST_KW_DO, dts_pkg::ST_KW_DOU, dts_pkg::ST_KW_DOUB,
          dts_pkg::ST_KW_DOUBL, dts_pkg::ST_KW_DOUBLE:
                               fin_kind = dts_pkg::KIND_IDENT;
          default:             fin = 1'b0;
        endcase
      end
      // new text starts from scratch
      scan_state_next    = dts_pkg::ST_START;
      lexeme_length_next = '0;
      lexeme_start_next  = '0;
      text_position_next = '0;
      line_count_next    = '0;
      halted_next        = 1'b0;
    end else if (!halted) begin
      text_position_next = text_position + 1'b1;
      line_count_next    = la;
      unique case (scan_state) inside
        dts_pkg::ST_INT: begin
          if (dts_pkg::is_digit(text_byte)) begin
            lexeme_length_next = ext_len;
          end else if (text_byte == dts_pkg::CH_DOT) begin
            lexeme_length_next = ext_len;
            scan_state_next    = dts_pkg::ST_DOT;
          end else begin
            fin      = 1'b1;
            fin_kind = dts_pkg::KIND_INT;
            rescan   = 1'b1;
          end
        end
        dts_pkg::ST_DOT: begin
          lexeme_length_next = ext_len;
          if (dts_pkg::is_digit(text_byte)) begin
            scan_state_next = dts_pkg::ST_FRAC;
          end else begin
            // malformed real: error includes this byte
            fin             = 1'b1;
            fin_kind        = dts_pkg::KIND_ERROR;
            fin_len         = ext_len;
            fin_line        = la;
            scan_state_next = dts_pkg::ST_START;
            halted_next     = 1'b1;
          end
        end
        dts_pkg::ST_FRAC: begin
          if (dts_pkg::is_digit(text_byte)) begin
            lexeme_length_next = ext_len;
          end else begin
            fin      = 1'b1;
            fin_kind = dts_pkg::KIND_REAL;
            rescan   = 1'b1;
          end
        end
        dts_pkg::ST_SLASH: begin
          if (text_byte == dts_pkg::CH_SLASH) begin
            lexeme_length_next = ext_len;
            scan_state_next    = dts_pkg::ST_COMMENT;
          end else begin
            fin      = 1'b1;
            fin_kind = dts_pkg::KIND_OP;
            rescan   = 1'b1;
          end
        end
        dts_pkg::ST_COMMENT: begin
          if (text_byte == dts_pkg::CH_NL) begin
            fin      = 1'b1;
            fin_kind = dts_pkg::KIND_COMMENT;
            rescan   = 1'b1;
          end else begin
            lexeme_length_next = ext_len;
          end
        end
        dts_pkg::ST_IDENT, dts_pkg::ST_KW_I, dts_pkg::ST_KW_IN, dts_pkg::ST_KW_INT,
        dts_pkg::ST_KW_D, dts_pkg::ST_KW_DO, dts_pkg::ST_KW_DOU, dts_pkg::ST_KW_DOUB,
        dts_pkg::ST_KW_DOUBL, dts_pkg::ST_KW_DOUBLE: begin
          if (scan_state != dts_pkg::ST_IDENT &&
              text_byte == dts_pkg::kw_expect(scan_state)) begin
            if (dts_pkg::kw_follow(scan_state) != dts_pkg::ST_START) begin
              lexeme_length_next = ext_len;
              scan_state_next    = dts_pkg::kw_follow(scan_state);
            end else begin
              fin      = 1'b1;
              fin_kind = dts_pkg::KIND_KEYWORD;
              rescan   = 1'b1;
            end
          end else if (dts_pkg::is_alpha(text_byte) || dts_pkg::is_digit(text_byte)) begin
            lexeme_length_next = ext_len;
            scan_state_next    = dts_pkg::ST_IDENT;
          end else begin
            fin      = 1'b1;
            fin_kind = dts_pkg::KIND_IDENT;
            rescan   = 1'b1;
          end
        end
        default: rescan = 1'b1;
      endcase

      if (rescan) begin
        scan_state_next = sc.nstate;
        if (sc.go) begin
          lexeme_start_next  = text_position;
          lexeme_length_next = {{(dts_pkg::LEN_W-1){1'b0}}, 1'b1};
        end
        if (sc.halt) begin
          halted_next = 1'b1;
        end
      end
    end

    pend_tok.kind   = fin_kind;
    pend_tok.start  = dts_pkg::START_W'(lexeme_start);
    pend_tok.length = fin_len;
    pend_tok.line   = fin_line;
    pend_tok.last   = 1'b0;

    sc_tok.kind   = sc.kind;
    sc_tok.start  = dts_pkg::START_W'(text_position);
    sc_tok.length = {{(dts_pkg::LEN_W-1){1'b0}}, 1'b1};
    sc_tok.line   = la;
    sc_tok.last   = 1'b1;

    // pending token goes first, a rescanned byte's token second
    res.valid0 = fin || (rescan && sc.emit);
    res.valid1 = fin && rescan && sc.emit;
    res.tok0   = fin ? pend_tok : sc_tok;
    res.tok0.last = !res.valid1;
    res.tok1   = sc_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state    <= dts_pkg::ST_START;
      lexeme_length <= '0;
      lexeme_start  <= '0;
      text_position <= '0;
      line_count    <= '0;
      halted        <= 1'b0;
    end else if (step) begin
      scan_state    <= scan_state_next;
      lexeme_length <= lexeme_length_next;
      lexeme_start  <= lexeme_start_next;
      text_position <= text_position_next;
      line_count    <= line_count_next;
      halted        <= halted_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/dts_result_fifo.sv -----
// ----------------------------------------------------------------------------
// dts_result_fifo
// Four-entry token queue that takes up to two tokens a cycle and gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module dts_result_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push0,
  input  wire logic             push1,
  input  dts_pkg::token_t       tok0,
  input  dts_pkg::token_t       tok1,
  input  wire logic             pop,
  output logic                  room2,
  output logic                  head_valid,
  output dts_pkg::token_t       head
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  dts_pkg::token_t    mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]   rd_ptr, rd_ptr_next;
  logic [PTR_W:0]     count, count_next;
  logic [PTR_W:0]     n_push;

  always_comb begin
    n_push      = {{PTR_W{1'b0}}, push0} + {{PTR_W{1'b0}}, push1};
    wr_ptr_next = wr_ptr + n_push[PTR_W-1:0];
    rd_ptr_next = pop ? rd_ptr + 1'b1 : rd_ptr;
    count_next  = count + n_push - {{PTR_W{1'b0}}, pop};
  end

  assign room2      = (count <= (PTR_W+1)'(DEPTH - 2));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_ptr] <= tok0;
    end
    if (push1) begin
      mem[wr_ptr + 1'b1] <= tok1;
    end
  end

endmodule

`default_nettype wire

// ----- src/dfa_token_scanner.sv -----
// ----------------------------------------------------------------------------
// dfa_token_scanner
// Byte-stream lexical scanner: one character per beat in, tokens out.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid / in_ready | text_byte, end_of_text
//  out     | out_valid/out_ready | token_kind, token_start, token_length,
//          |                     | line_number, last_of_run
//
//  a beat sits in the input register, then one scanner step writes its
//  tokens into a four-entry result queue; the first token passes the input
//  register and then the queue before it can leave. one beat per cycle is
//  sustained while the queue drains; a beat giving two tokens hands them
//  out one at a time. the step waits while the queue has fewer than two
//  free entries. rst clears scanner and queue state.
// ----------------------------------------------------------------------------
`default_nettype none

module dfa_token_scanner #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  text_byte,
  input  wire logic        end_of_text,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       token_kind,
  output logic [15:0]      token_start,
  output logic [7:0]       token_length,
  output logic [15:0]      line_number,
  output logic             last_of_run
);

  logic               ib_valid;
  logic [7:0]         ib_byte;
  logic               ib_eot;
  logic               step;
  logic               room2;
  dts_pkg::step_out_t res;
  dts_pkg::token_t    head;

  assign step     = ib_valid && room2;
  assign in_ready = !ib_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      ib_valid <= 1'b0;
    end else if (in_ready) begin
      ib_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ib_byte <= text_byte;
      ib_eot  <= end_of_text;
    end
  end

  dts_scan_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .text_byte   (ib_byte),
    .end_of_text (ib_eot),
    .res         (res)
  );

  dts_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push0      (step && res.valid0),
    .push1      (step && res.valid1),
    .tok0       (res.tok0),
    .tok1       (res.tok1),
    .pop        (out_valid && out_ready),
    .room2      (room2),
    .head_valid (out_valid),
    .head       (head)
  );

  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign line_number  = head.line;
  assign last_of_run  = head.last;

endmodule

`default_nettype wire

// ----- tb/sv/dfa_token_scanner_tb.sv -----
// ----------------------------------------------------------------------------
// dfa_token_scanner_tb
// Streams source text into the scanner through random feed and sink stalls.
// A built-in scanner model predicts every token from each accepted input beat,
// and each output beat is checked field by field against the oldest one.
// Stimulus covers short hand-written texts, a lexeme long enough to saturate
// its length, and random token soup.
// ----------------------------------------------------------------------------
module dfa_token_scanner_tb;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned TAIL_CYCLES  = 16;
  localparam int unsigned RANDOM_BEATS = 100;
  localparam int unsigned LONG_ALNUM   = 258;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } text_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  text_byte = 8'h00;
  logic        end_of_text = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  token_kind;
  logic [15:0] token_start;
  logic [7:0]  token_length;
  logic [15:0] line_number;
  logic        last_of_run;

  text_beat_t       pending_beats[$];
  dts_pkg::token_t  beat_tokens[$];
  dts_pkg::token_t  expected_tokens[$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          feed_pause = 0;
  int          sink_pause = 0;
  bit          feed_steady = 1'b0;
  bit          sink_steady = 1'b0;

  // scanner model state
  dts_pkg::scan_state_t model_state;
  logic [7:0]  model_len;
  logic [15:0] model_start;
  logic [15:0] model_pos;
  logic [15:0] model_lines;
  logic        model_halted;

  dfa_token_scanner u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .text_byte    (text_byte),
    .end_of_text  (end_of_text),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .line_number  (line_number),
    .last_of_run  (last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic logic is_num(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic void model_clear();
    model_state  = dts_pkg::ST_START;
    model_len    = '0;
    model_start  = '0;
    model_pos    = '0;
    model_lines  = '0;
    model_halted = 1'b0;
  endfunction

  function automatic void record_token(dts_pkg::kind_t k, logic [15:0] s, logic [7:0] l,
                                       logic [15:0] ln);
    dts_pkg::token_t t;
    t.kind   = k;
    t.start  = s;
    t.length = l;
    t.line   = ln;
    t.last   = 1'b0;
    beat_tokens.push_back(t);
  endfunction

  function automatic void open_lexeme(dts_pkg::scan_state_t st, logic [15:0] pos);
    model_state = st;
    model_start = pos;
    model_len   = 8'd1;
  endfunction

  function automatic void grow_lexeme();
    if (model_len != 8'hFF) model_len = model_len + 8'd1;
  endfunction

  function automatic logic [7:0] keyword_want(dts_pkg::scan_state_t st);
    case (st)
      dts_pkg::ST_KW_I:     return dts_pkg::CH_LC_N;
      dts_pkg::ST_KW_IN:    return dts_pkg::CH_LC_T;
      dts_pkg::ST_KW_D:     return dts_pkg::CH_LC_O;
      dts_pkg::ST_KW_DO:    return dts_pkg::CH_LC_U;
      dts_pkg::ST_KW_DOU:   return dts_pkg::CH_LC_B;
      dts_pkg::ST_KW_DOUB:  return dts_pkg::CH_LC_L;
      dts_pkg::ST_KW_DOUBL: return dts_pkg::CH_LC_E;
      default:              return dts_pkg::CH_SPACE;
    endcase
  endfunction

  // ST_START once the whole keyword has been seen
  function automatic dts_pkg::scan_state_t keyword_next(dts_pkg::scan_state_t st);
    case (st)
      dts_pkg::ST_KW_I:     return dts_pkg::ST_KW_IN;
      dts_pkg::ST_KW_IN:    return dts_pkg::ST_KW_INT;
      dts_pkg::ST_KW_D:     return dts_pkg::ST_KW_DO;
      dts_pkg::ST_KW_DO:    return dts_pkg::ST_KW_DOU;
      dts_pkg::ST_KW_DOU:   return dts_pkg::ST_KW_DOUB;
      dts_pkg::ST_KW_DOUB:  return dts_pkg::ST_KW_DOUBL;
      dts_pkg::ST_KW_DOUBL: return dts_pkg::ST_KW_DOUBLE;
      default:              return dts_pkg::ST_START;
    endcase
  endfunction

  function automatic void scan_fresh(logic [7:0] c, logic [15:0] pos, logic [15:0] ln);
    model_state = dts_pkg::ST_START;
    if (c == dts_pkg::CH_SPACE || c == dts_pkg::CH_NL || c == dts_pkg::CH_TAB) begin
      model_state = dts_pkg::ST_START;
    end else if (c == dts_pkg::CH_SEMI || c == dts_pkg::CH_EQ) begin
      record_token(dts_pkg::KIND_SEP, pos, 8'd1, ln);
    end else if (c == dts_pkg::CH_PLUS || c == dts_pkg::CH_MINUS ||
                 c == dts_pkg::CH_STAR) begin
      record_token(dts_pkg::KIND_OP, pos, 8'd1, ln);
    end else if (is_num(c)) begin
      open_lexeme(dts_pkg::ST_INT, pos);
    end else if (c == dts_pkg::CH_SLASH) begin
      open_lexeme(dts_pkg::ST_SLASH, pos);
    end else if (c == dts_pkg::CH_LC_I) begin
      open_lexeme(dts_pkg::ST_KW_I, pos);
    end else if (c == dts_pkg::CH_LC_D) begin
      open_lexeme(dts_pkg::ST_KW_D, pos);
    end else if (is_letter(c)) begin
      open_lexeme(dts_pkg::ST_IDENT, pos);
    end else begin
      record_token(dts_pkg::KIND_ERROR, pos, 8'd1, ln);
      model_halted = 1'b1;
    end
  endfunction

  // pending token ends before c, which is then scanned from the start state
  function automatic void end_and_rescan(dts_pkg::kind_t k, logic [7:0] c,
                                         logic [15:0] pos,
                                         logic [15:0] lb, logic [15:0] la);
    record_token(k, model_start, model_len, lb);
    scan_fresh(c, pos, la);
  endfunction

  function automatic void ident_or_rescan(logic [7:0] c, logic [15:0] pos,
                                          logic [15:0] lb, logic [15:0] la);
    if (is_letter(c) || is_num(c)) begin
      grow_lexeme();
      model_state = dts_pkg::ST_IDENT;
    end else begin
      end_and_rescan(dts_pkg::KIND_IDENT, c, pos, lb, la);
    end
  endfunction

  function automatic void predict_beat(logic [7:0] c, logic eot);
    logic [15:0]     pos;
    logic [15:0]     lb;
    logic [15:0]     la;
    dts_pkg::token_t t;
    beat_tokens.delete();
    if (eot) begin
      if (!model_halted) begin
        case (model_state)
          dts_pkg::ST_START:
            model_state = dts_pkg::ST_START;
          dts_pkg::ST_INT:
            record_token(dts_pkg::KIND_INT, model_start, model_len, model_lines);
          dts_pkg::ST_DOT:
            record_token(dts_pkg::KIND_ERROR, model_start, model_len, model_lines);
          dts_pkg::ST_FRAC:
            record_token(dts_pkg::KIND_REAL, model_start, model_len, model_lines);
          dts_pkg::ST_SLASH:
            record_token(dts_pkg::KIND_OP, model_start, model_len, model_lines);
          dts_pkg::ST_COMMENT:
            record_token(dts_pkg::KIND_COMMENT, model_start, model_len, model_lines);
          default:
            record_token(dts_pkg::KIND_IDENT, model_start, model_len, model_lines);
        endcase
      end
      model_clear();
    end else if (!model_halted) begin
      pos = model_pos;
      lb  = model_lines;
      la  = (c == dts_pkg::CH_NL && lb != 16'hFFFF) ? lb + 16'd1 : lb;
      model_pos   = pos + 16'd1;
      model_lines = la;
      case (model_state)
        dts_pkg::ST_START: scan_fresh(c, pos, la);
        dts_pkg::ST_INT: begin
          if (is_num(c)) begin
            grow_lexeme();
          end else if (c == dts_pkg::CH_DOT) begin
            grow_lexeme();
            model_state = dts_pkg::ST_DOT;
          end else begin
            end_and_rescan(dts_pkg::KIND_INT, c, pos, lb, la);
          end
        end
        dts_pkg::ST_DOT: begin
          grow_lexeme();
          if (is_num(c)) begin
            model_state = dts_pkg::ST_FRAC;
          end else begin
            // malformed real keeps the offending byte in its lexeme
            record_token(dts_pkg::KIND_ERROR, model_start, model_len, la);
            model_state  = dts_pkg::ST_START;
            model_halted = 1'b1;
          end
        end
        dts_pkg::ST_FRAC: begin
          if (is_num(c)) grow_lexeme();
          else end_and_rescan(dts_pkg::KIND_REAL, c, pos, lb, la);
        end
        dts_pkg::ST_SLASH: begin
          if (c == dts_pkg::CH_SLASH) begin
            grow_lexeme();
            model_state = dts_pkg::ST_COMMENT;
          end else begin
            end_and_rescan(dts_pkg::KIND_OP, c, pos, lb, la);
          end
        end
        dts_pkg::ST_COMMENT: begin
          if (c == dts_pkg::CH_NL) end_and_rescan(dts_pkg::KIND_COMMENT, c, pos, lb, la);
          else grow_lexeme();
        end
        dts_pkg::ST_IDENT: ident_or_rescan(c, pos, lb, la);
        default: begin
          if (c == keyword_want(model_state)) begin
            if (keyword_next(model_state) != dts_pkg::ST_START) begin
              grow_lexeme();
              model_state = keyword_next(model_state);
            end else begin
              end_and_rescan(dts_pkg::KIND_KEYWORD, c, pos, lb, la);
            end
          end else begin
            ident_or_rescan(c, pos, lb, la);
          end
        end
      endcase
    end
    if (beat_tokens.size() > 0) begin
      t = beat_tokens.pop_back();
      t.last = 1'b1;
      beat_tokens.push_back(t);
    end
    foreach (beat_tokens[i]) expected_tokens.push_back(beat_tokens[i]);
  endfunction

  // ------------------------------------------------------------- stimulus

  function automatic void put_byte(logic [7:0] c);
    text_beat_t b;
    b.ch  = c;
    b.eot = 1'b0;
    pending_beats.push_back(b);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  // byte under an end mark is ignored, so it is random
  function automatic void put_end();
    text_beat_t b;
    b.ch  = 8'($urandom_range(0, 255));
    b.eot = 1'b1;
    pending_beats.push_back(b);
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(8'h61, 8'h7A));
    return 8'($urandom_range(8'h41, 8'h5A));
  endfunction

  function automatic logic [7:0] rand_alnum();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(8'h30, 8'h39));
    return rand_letter();
  endfunction

  function automatic void put_digits(int n);
    repeat (n) put_byte(8'($urandom_range(8'h30, 8'h39)));
  endfunction

  function automatic logic [7:0] comment_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == dts_pkg::CH_NL);
    return c;
  endfunction

  function automatic logic starts_token(logic [7:0] c);
    return c == dts_pkg::CH_SPACE || c == dts_pkg::CH_NL || c == dts_pkg::CH_TAB ||
           c == dts_pkg::CH_SEMI || c == dts_pkg::CH_EQ || c == dts_pkg::CH_PLUS ||
           c == dts_pkg::CH_MINUS || c == dts_pkg::CH_STAR || c == dts_pkg::CH_SLASH ||
           is_num(c) || is_letter(c);
  endfunction

  function automatic string pick_keyword();
    if ($urandom_range(0, 1) == 0) return "int";
    return "double";
  endfunction

  function automatic void put_fragment();
    string kw;
    int    n;
    kw = pick_keyword();
    case ($urandom_range(0, 9))
      0: put_byte($urandom_range(0, 1) == 0 ? dts_pkg::CH_SEMI : dts_pkg::CH_EQ);
      1: begin
        case ($urandom_range(0, 3))
          0: put_byte(dts_pkg::CH_PLUS);
          1: put_byte(dts_pkg::CH_MINUS);
          2: put_byte(dts_pkg::CH_STAR);
          default: put_byte(dts_pkg::CH_SLASH);
        endcase
      end
      2: put_digits($urandom_range(1, 6));
      3: begin
        put_digits($urandom_range(1, 4));
        put_byte(dts_pkg::CH_DOT);
        put_digits($urandom_range(1, 4));
      end
      4: begin
        put_byte(dts_pkg::CH_SLASH);
        put_byte(dts_pkg::CH_SLASH);
        n = $urandom_range(0, 10);
        repeat (n) put_byte(comment_byte());
        if ($urandom_range(0, 4) != 0) put_byte(dts_pkg::CH_NL);
      end
      5: begin
        put_text(kw);
        put_byte(dts_pkg::CH_SPACE);
      end
      6: put_text(kw.substr(0, $urandom_range(0, kw.len() - 1)));
      7: begin
        // keyword prefix broken by a letter or digit
        put_text(kw.substr(0, $urandom_range(0, kw.len() - 1)));
        repeat ($urandom_range(1, 3)) put_byte(rand_alnum());
      end
      8: begin
        case ($urandom_range(0, 3))
          0: put_byte(dts_pkg::CH_LC_I);
          1: put_byte(dts_pkg::CH_LC_D);
          default: put_byte(rand_letter());
        endcase
        repeat ($urandom_range(0, 7)) put_byte(rand_alnum());
      end
      default: begin
        // complete keyword not followed by a space
        put_text(kw);
        case ($urandom_range(0, 4))
          0: put_byte(dts_pkg::CH_SEMI);
          1: put_byte(dts_pkg::CH_TAB);
          2: put_byte(dts_pkg::CH_NL);
          3: put_byte(dts_pkg::CH_PLUS);
          default: put_byte(dts_pkg::CH_EQ);
        endcase
      end
    endcase
  endfunction

  function automatic void put_spacing();
    case ($urandom_range(0, 5))
      2: put_byte(dts_pkg::CH_SPACE);
      3: put_byte(dts_pkg::CH_TAB);
      4: put_byte(dts_pkg::CH_NL);
      5: put_text("  ");
      default: ;
    endcase
  endfunction

  function automatic void put_fault();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 0) begin
      do c = 8'($urandom_range(0, 255)); while (starts_token(c));
      put_byte(c);
    end else begin
      put_digits($urandom_range(1, 3));
      put_byte(dts_pkg::CH_DOT);
      do c = 8'($urandom_range(0, 255)); while (is_num(c));
      put_byte(c);
    end
  endfunction

  function automatic void build_directed();
    put_text("int 7.25;x=-3*/");
    put_end();
    put_text("double\n//");
    put_byte(8'hFF);
    put_end();
    put_text("12.a zz");
    put_end();
    put_text("5.");
    put_end();
    put_byte(8'h00);
    put_text("a");
    put_end();
    put_text("i9 d");
    put_byte(8'hFF);
    put_end();
    put_end();
  endfunction

  function automatic void build_long();
    // identifier longer than the length field can count
    put_byte(dts_pkg::CH_LC_D);
    repeat (LONG_ALNUM) put_byte(rand_alnum());
    put_byte(dts_pkg::CH_SEMI);
    put_end();
  endfunction

  function automatic void build_random();
    int made;
    int text_head;
    made = 0;
    while (made < RANDOM_BEATS) begin
      text_head = pending_beats.size();
      repeat ($urandom_range(1, 12)) begin
        put_fragment();
        put_spacing();
      end
      if ($urandom_range(0, 7) == 0) put_fault();
      made += pending_beats.size() - text_head + 1;
      // bytes after a fault are ignored by the scanner
      if ($urandom_range(0, 1) == 0) repeat ($urandom_range(1, 4))
        put_byte(8'($urandom_range(0, 255)));
      put_end();
    end
  endfunction

  // ------------------------------------------------------ feed and sink

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  always @(posedge clk) begin : driver
    text_beat_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (feed_pause > 0) begin
        feed_pause = feed_pause - 1;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        nxt = pending_beats.pop_front();
        text_byte   <= nxt.ch;
        end_of_text <= nxt.eot;
        in_valid    <= 1'b1;
        if ($urandom_range(0, 63) == 0) feed_steady = !feed_steady;
        feed_pause = feed_steady ? 0 : idle_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    dts_pkg::token_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_beat(text_byte, end_of_text);
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          $error("token beat with none expected: kind %0d start %0d",
                 token_kind, token_start);
          mismatch_count++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("token_kind", 16'(want.kind), 16'(token_kind));
          check_field("token_start", want.start, token_start);
          check_field("token_length", 16'(want.length), 16'(token_length));
          check_field("line_number", want.line, line_number);
          check_field("last_of_run", 16'(want.last), 16'(last_of_run));
        end
      end
      if (sink_pause > 0) begin
        sink_pause = sink_pause - 1;
        out_ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) sink_steady = !sink_steady;
        sink_pause = sink_steady ? 0 : idle_gap();
        out_ready <= (sink_pause == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    model_clear();
    build_directed();
    build_long();
    build_random();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // sample on the falling edge so the rising-edge processes have settled
    @(negedge clk);
    while (pending_beats.size() != 0 || in_valid) @(negedge clk);
    while (expected_tokens.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/dts_pkg.sv
src/dts_scan_core.sv
src/dts_result_fifo.sv
src/dfa_token_scanner.sv
tb/sv/dfa_token_scanner_tb.sv
